/* hw/rtl/sq8qd_pkg.sv */
`timescale 1ns / 1ps
package sq8qd_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int CNT_W     = 17;
	localparam int ACC_W     = 49;
	localparam int SCORE_W   = 54;
	localparam int QDEPTH    = 4;
	localparam int ODEPTH    = 2;
	localparam int CFG_W     = 28;
	localparam int CFG_IDX_W = 3;

	// ceil(2^32 / 255); exact floor division for every code * range product
	localparam logic [24:0] RECIP_255 = 25'd16843010;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE  = 3'd0,
		CFG_MIN   = 3'd1,
		CFG_MAX   = 3'd2,
		CFG_SCALE = 3'd3,
		CFG_QSUM  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] query_element;
		logic [7:0]         code;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      overflow;
	} result_t;

	typedef struct packed {
		item_t item;
		logic  skip;
		logic  ovf;
	} entry_t;

	typedef struct packed {
		logic               metric_mode;
		logic signed [15:0] min_value;
		logic signed [15:0] max_value;
		logic [23:0]        dot_scale;
		logic signed [27:0] query_sum;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic push;
	} back_status_t;

endpackage

/* hw/rtl/sq8qd_front.sv */
`timescale 1ns / 1ps
module sq8qd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             q_full,
	input  sq8qd_pkg::item_t item,
	output logic             full,
	output logic             wr,
	output sq8qd_pkg::entry_t entry
);
	import sq8qd_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             skip;

	assign full = q_full;
	assign wr   = push && !q_full;
	// past the dimension limit an element is counted out but still passed on for its last marker
	assign skip = (count_q >= CNT_W'(MAX_DIM));

	always_comb begin
		entry.item = item;
		entry.skip = skip;
		entry.ovf  = ovf_q | skip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (wr) begin
			if (item.last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (!skip) begin
					count_q <= count_q + CNT_W'(1);
				end
				ovf_q <= ovf_q | skip;
			end
		end
	end

endmodule

/* hw/rtl/sq8qd_queue.sv */
`timescale 1ns / 1ps
module sq8qd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  sq8qd_pkg::entry_t wdata,
	output logic              full,
	input  logic              rd,
	output sq8qd_pkg::entry_t rdata,
	output logic              nonempty
);
	import sq8qd_pkg::*;

	localparam int A_W = $clog2(QDEPTH);

	entry_t         mem_q [QDEPTH];
	logic [A_W-1:0] wptr_q;
	logic [A_W-1:0] rptr_q;
	logic [A_W:0]   cnt_q;

	assign full     = (cnt_q == (A_W+1)'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + A_W'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + A_W'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + (A_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (A_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/sq8qd_back.sv */
`timescale 1ns / 1ps
module sq8qd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sq8qd_pkg::cfg_t         cfg,
	input  logic                    q_nonempty,
	input  sq8qd_pkg::entry_t       q_data,
	output logic                    q_rd,
	output logic                    empty,
	input  logic                    pop,
	output sq8qd_pkg::result_t      result,
	output sq8qd_pkg::back_status_t status
);
	import sq8qd_pkg::*;

	localparam int SUM_W = 67;
	localparam int OA_W  = $clog2(ODEPTH);
	localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SCORE_W-1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (SCORE_W-1));

	logic adv;
	logic ofull;

	// stage 1: code times quantizer range
	logic               v_s1;
	entry_t             e_s1;
	logic [23:0]        x_s1;
	logic signed [16:0] diff;
	logic [15:0]        rng;

	// stage 2: divide by 255, dequantize, subtract
	logic               v_s2;
	entry_t             e_s2;
	logic signed [17:0] d_s2;
	logic [48:0]        dq_prod;
	logic signed [17:0] deq;

	// stage 3: square or product
	logic               v_s3;
	logic               last_s3;
	logic               ovf_s3;
	logic signed [35:0] term_s3;
	logic signed [35:0] sq;
	logic signed [35:0] pr;

	// stage 4: accumulator
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_sum;
	logic                    fin_v_s4;
	logic signed [ACC_W-1:0] facc_s4;
	logic                    fovf_s4;

	// stage 5, 6: final scaling
	logic                    fin_v_s5;
	logic signed [ACC_W-1:0] facc_s5;
	logic                    fovf_s5;
	logic signed [49:0]      p_hi_s5;
	logic [47:0]             p_lo_s5;
	logic signed [43:0]      p_qm_s5;

	logic                    fin_v_s6;
	logic signed [ACC_W-1:0] facc_s6;
	logic                    fovf_s6;
	logic signed [65:0]      prod_s6;
	logic signed [43:0]      qm_s6;
	logic signed [73:0]      wide;

	logic signed [SUM_W-1:0] total;
	logic                    sat_hi;
	logic                    sat_lo;
	result_t                 res;
	logic                    opush;

	// result queue
	result_t         ores_q [ODEPTH];
	logic [OA_W-1:0] owp_q;
	logic [OA_W-1:0] orp_q;
	logic [OA_W:0]   ocnt_q;
	logic            opop;

	// whole pipeline holds while a finished result cannot enter the result queue
	assign adv  = !(fin_v_s6 && ofull);
	assign q_rd = q_nonempty && adv;

	assign diff = 17'(cfg.max_value) - 17'(cfg.min_value);
	assign rng  = (cfg.max_value > cfg.min_value) ? diff[15:0] : 16'd0;

	assign dq_prod = 49'(x_s1) * 49'(RECIP_255);
	assign deq     = 18'(cfg.min_value) + 18'({2'b00, dq_prod[47:32]});

	assign sq = 36'(d_s2) * 36'(d_s2);
	assign pr = 36'(e_s2.item.query_element) * 36'({1'b0, e_s2.item.code});

	assign acc_sum = acc_q + ACC_W'(term_s3);

	assign wide = (74'(p_hi_s5) <<< 24) + 74'({26'b0, p_lo_s5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			fin_v_s4 <= 1'b0;
			fin_v_s5 <= 1'b0;
			fin_v_s6 <= 1'b0;
			acc_q    <= '0;
		end else if (adv) begin
			v_s1     <= q_nonempty;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			fin_v_s4 <= v_s3 && last_s3;
			fin_v_s5 <= fin_v_s4;
			fin_v_s6 <= fin_v_s5;
			if (v_s3) begin
				acc_q <= last_s3 ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= q_data;
			x_s1 <= 24'(q_data.item.code) * 24'(rng);

			e_s2 <= e_s1;
			d_s2 <= 18'(e_s1.item.query_element) - deq;

			last_s3 <= e_s2.item.last;
			ovf_s3  <= e_s2.ovf;
			term_s3 <= e_s2.skip ? '0 : (cfg.metric_mode ? sq : pr);

			facc_s4 <= acc_sum;
			fovf_s4 <= ovf_s3;

			// acc * scale split at bit 24 to keep each multiplier near 25 x 25
			facc_s5 <= facc_s4;
			fovf_s5 <= fovf_s4;
			p_hi_s5 <= $signed(facc_s4[ACC_W-1:24]) * $signed({1'b0, cfg.dot_scale});
			p_lo_s5 <= 48'(facc_s4[23:0]) * 48'(cfg.dot_scale);
			p_qm_s5 <= 44'(cfg.query_sum) * 44'(cfg.min_value);

			facc_s6 <= facc_s5;
			fovf_s6 <= fovf_s5;
			prod_s6 <= $signed(wide[73:8]);
			qm_s6   <= p_qm_s5;
		end
	end

	always_comb begin
		if (cfg.metric_mode) begin
			total = SUM_W'(facc_s6);
		end else begin
			total = SUM_W'(prod_s6) + SUM_W'(qm_s6);
		end
		sat_hi = (total > SAT_HI);
		sat_lo = (total < SAT_LO);
		if (sat_hi) begin
			res.score = SAT_HI[SCORE_W-1:0];
		end else if (sat_lo) begin
			res.score = SAT_LO[SCORE_W-1:0];
		end else begin
			res.score = total[SCORE_W-1:0];
		end
		res.overflow = fovf_s6 | sat_hi | sat_lo;
	end

	assign opush = fin_v_s6 && adv;
	assign opop  = pop && !empty;
	assign ofull = (ocnt_q == (OA_W+1)'(ODEPTH));
	assign empty = (ocnt_q == '0);
	assign result = ores_q[orp_q];

	always_ff @(posedge clk) begin
		if (opush) begin
			ores_q[owp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owp_q <= owp_q + OA_W'(1);
			end
			if (opop) begin
				orp_q <= orp_q + OA_W'(1);
			end
			case ({opush, opop})
				2'b10:   ocnt_q <= ocnt_q + (OA_W+1)'(1);
				2'b01:   ocnt_q <= ocnt_q - (OA_W+1)'(1);
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assign status.busy = v_s1 | v_s2 | v_s3 | fin_v_s4 | fin_v_s5 | fin_v_s6;
	assign status.push = opush;

endmodule

/* hw/rtl/sq8_quantized_distance_unit.sv */
`timescale 1ns / 1ps
// Streaming 8-bit scalar-quantized distance unit. Each item carries one query element (signed
// Q8.8), its database code and a last marker; the unit takes one item per clock while the
// result queue has room, and on the last item of a vector the score (times 2^16, saturated
// to 54 bits) can be popped once that item has passed the pipeline and entered the result
// queue. The rate is set by the accumulator add, which sits behind a three-stage
// dequantize/multiply pipeline and ahead of the final scaling stages; a four-entry queue
// sits between the input counter and that pipeline, and a two-entry queue holds results, so
// the input stalls only when both queues back up. Elements beyond MAX_DIM in one vector are
// not summed and set the overflow flag. Registers: 0 metric mode, 1 min, 2 max, 3 dot scale,
// 4 query sum; write them only while no vector is in flight.
module sq8_quantized_distance_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  sq8qd_pkg::item_t                  item,
	output logic                              empty,
	input  logic                              pop,
	output sq8qd_pkg::result_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sq8qd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sq8qd_pkg::CFG_W-1:0]       cfg_data
);
	import sq8qd_pkg::*;

	cfg_t         cfg_q;
	logic         q_full;
	logic         q_wr;
	entry_t       q_wdata;
	logic         q_rd;
	entry_t       q_rdata;
	logic         q_nonempty;
	back_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:  cfg_q.metric_mode <= cfg_data[0];
				CFG_MIN:   cfg_q.min_value   <= cfg_data[15:0];
				CFG_MAX:   cfg_q.max_value   <= cfg_data[15:0];
				CFG_SCALE: cfg_q.dot_scale   <= cfg_data[23:0];
				CFG_QSUM:  cfg_q.query_sum   <= cfg_data[27:0];
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	sq8qd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.q_full (q_full),
		.item   (item),
		.full   (full),
		.wr     (q_wr),
		.entry  (q_wdata)
	);

	sq8qd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wdata    (q_wdata),
		.full     (q_full),
		.rd       (q_rd),
		.rdata    (q_rdata),
		.nonempty (q_nonempty)
	);

	sq8qd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.q_data     (q_rdata),
		.q_rd       (q_rd),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.status     (status)
	);

	// a result only shows after the back end pushed one
	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(status.push))
		else $error("result appeared without a push");

	// an accepted item is held in the queue on the next cycle
	a_item_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> q_nonempty)
		else $error("accepted item lost before the queue");

	// with nothing queued or in flight no result can be produced
	a_no_spurious_push: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_nonempty && !status.busy) |=> !status.push)
		else $error("result pushed with an idle pipeline");

endmodule
